[rtl/polyev_pkg.sv]
// Shared types, register map and defaults for the polynomial evaluator.
package polyev_pkg;

    localparam int MAX_DEGREE_DEF = 6;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int NCOEF          = 7;
    localparam int CFG_IDX_W      = 4;

    localparam logic [CFG_IDX_W-1:0] REG_DEGREE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF0  = 4'd1;

    localparam logic REQ_EVAL     = 1'b0;
    localparam logic REQ_INTEGRAL = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic signed [31:0] point_or_lower;
        logic signed [31:0] upper_bound;
    } pe_in_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               overflow;
    } pe_out_t;

    // One pipeline slot: both lanes travel together. va/vb hold either a
    // sign-extended accumulator or a full product, depending on the stage.
    typedef struct packed {
        logic               req_type;
        logic signed [31:0] xa;
        logic signed [31:0] xb;
        logic signed [63:0] va;
        logic signed [63:0] vb;
        logic               ovf;
    } pe_stage_t;

endpackage

[rtl/polynomial_evaluator.sv]
// Pipelined Horner polynomial evaluator and definite integrator, signed fixed point.
// Throughput: one request per cycle unless out_stall or the divider holds the pipeline;
// each Horner step is a multiply stage and a round/add/saturate stage, with lanes for
// both bounds running side by side. A coefficient write computes its integral
// coefficient by reciprocal multiplication, with in_stall high and cfg_ready low.
// Reset clears degree and coefficients.
module polynomial_evaluator #(
    parameter int MAX_DEGREE = polyev_pkg::MAX_DEGREE_DEF,
    parameter int FRAC_BITS  = polyev_pkg::FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  polyev_pkg::pe_in_t               in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output polyev_pkg::pe_out_t              out_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [polyev_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                      cfg_data
);

    localparam int NSTEP = MAX_DEGREE + 1;
    localparam int NST   = 2 * NSTEP + 1;
    localparam logic [2:0] MAXD = 3'(MAX_DEGREE);
    localparam logic [polyev_pkg::CFG_IDX_W-1:0] COEF_END =
        polyev_pkg::CFG_IDX_W'(int'(polyev_pkg::REG_COEF0) + polyev_pkg::NCOEF);
    localparam logic signed [65:0] HALF   = 66'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [65:0] S32MAX = 66'sd2147483647;
    localparam logic signed [65:0] S32MIN = -66'sd2147483648;

    // ------------------------------------------------------------------
    // Configuration registers and integral coefficient divider
    // ------------------------------------------------------------------
    logic [2:0]         degree_reg;
    logic signed [31:0] coef_reg [0:polyev_pkg::NCOEF-1];
    logic signed [31:0] anti_reg [0:polyev_pkg::NCOEF-1];

    logic        div_busy_reg;
    logic        div_mul_done_reg;
    logic [31:0] div_num_reg;
    logic [31:0] div_recip_reg;
    logic [3:0]  div_k_reg;
    logic        div_neg_reg;
    logic [2:0]  div_idx_reg;
    logic [63:0] div_prod_reg;

    logic        cfg_fire;
    logic        coef_wr;
    logic [2:0]  coef_sel;
    logic [3:0]  coef_k;
    logic [31:0] coef_mag;
    logic [31:0] div_recip;
    logic [31:0] div_q_est;
    logic [34:0] div_qk;
    logic [34:0] div_rem;
    logic [31:0] div_q;
    logic [31:0] div_q_signed;

    assign cfg_ready = !div_busy_reg;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign coef_wr   = cfg_fire && (cfg_index >= polyev_pkg::REG_COEF0)
                       && (cfg_index < COEF_END);
    assign coef_sel  = 3'(cfg_index - polyev_pkg::REG_COEF0);
    assign coef_k    = {1'b0, coef_sel} + 4'd1;
    assign coef_mag  = cfg_data[31] ? (32'd0 - cfg_data) : cfg_data;

    // floor(2^32 / k), saturated to 32 bits for k = 1; the estimate below is short by at most one
    always_comb
    begin
        case (coef_sel)
            3'd0:    div_recip = 32'hFFFF_FFFF;
            3'd1:    div_recip = 32'h8000_0000;
            3'd2:    div_recip = 32'h5555_5555;
            3'd3:    div_recip = 32'h4000_0000;
            3'd4:    div_recip = 32'h3333_3333;
            3'd5:    div_recip = 32'h2AAA_AAAA;
            default: div_recip = 32'h2492_4924;
        endcase
    end

    assign div_q_est    = div_prod_reg[63:32];
    assign div_qk       = {3'b000, div_q_est} * {31'd0, div_k_reg};
    assign div_rem      = {3'b000, div_num_reg} - div_qk;
    assign div_q        = div_q_est + {31'd0, div_rem >= {31'd0, div_k_reg}};
    assign div_q_signed = div_neg_reg ? (32'd0 - div_q) : div_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            degree_reg       <= '0;
            div_busy_reg     <= 1'b0;
            div_mul_done_reg <= 1'b0;
            div_num_reg      <= '0;
            div_recip_reg    <= '0;
            div_k_reg        <= '0;
            div_neg_reg      <= 1'b0;
            div_idx_reg      <= '0;
            div_prod_reg     <= '0;
            for (int i = 0; i < polyev_pkg::NCOEF; i++)
            begin
                coef_reg[i] <= '0;
                anti_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_fire && cfg_index == polyev_pkg::REG_DEGREE)
            begin
                degree_reg <= cfg_data[2:0];
            end
            if (coef_wr)
            begin
                coef_reg[coef_sel] <= cfg_data;
                div_busy_reg       <= 1'b1;
                div_mul_done_reg   <= 1'b0;
                // round(m/k) = floor((m + floor(k/2)) / k)
                div_num_reg        <= coef_mag + {29'd0, coef_k[3:1]};
                div_recip_reg      <= div_recip;
                div_k_reg          <= coef_k;
                div_neg_reg        <= cfg_data[31];
                div_idx_reg        <= coef_sel;
            end
            else if (div_busy_reg)
            begin
                if (!div_mul_done_reg)
                begin
                    div_prod_reg     <= div_num_reg * div_recip_reg;
                    div_mul_done_reg <= 1'b1;
                end
                else
                begin
                    div_busy_reg          <= 1'b0;
                    anti_reg[div_idx_reg] <= div_q_signed;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Coefficient vectors, zero-padded above the effective degree
    // ------------------------------------------------------------------
    logic [2:0]         d_eff;
    logic signed [31:0] cf_eval [0:MAX_DEGREE];
    logic signed [31:0] cf_int  [0:MAX_DEGREE];
    logic signed [31:0] init_int;

    assign d_eff    = (degree_reg > MAXD) ? MAXD : degree_reg;
    assign init_int = (d_eff == MAXD) ? anti_reg[MAX_DEGREE] : '0;

    for (genvar j = 0; j <= MAX_DEGREE; j++)
    begin : g_coef
        assign cf_eval[j] = ({1'b0, d_eff} >= 4'(j)) ? coef_reg[j] : '0;
        if (j == 0)
        begin : g_zero
            assign cf_int[j] = '0;
        end
        else
        begin : g_anti
            assign cf_int[j] = ({1'b0, d_eff} + 4'd1 >= 4'(j)) ? anti_reg[j-1] : '0;
        end
    end

    // ------------------------------------------------------------------
    // Horner pipeline with bubble-collapsing flow control
    // ------------------------------------------------------------------
    function automatic logic [32:0] horner_add(input logic signed [63:0] prod,
                                              input logic signed [31:0] c);
        logic signed [65:0] p;
        logic signed [65:0] r;
        logic signed [65:0] s;
        logic [32:0]        res;
        // round half away from zero: bias negatives down by one, then floor
        p = {{2{prod[63]}}, prod} + HALF - (prod[63] ? 66'sd1 : 66'sd0);
        r = p >>> FRAC_BITS;
        s = r + {{34{c[31]}}, c};
        if (s > S32MAX)
        begin
            res = {1'b1, 32'h7fff_ffff};
        end
        else if (s < S32MIN)
        begin
            res = {1'b1, 32'h8000_0000};
        end
        else
        begin
            res = {1'b0, s[31:0]};
        end
        return res;
    endfunction

    polyev_pkg::pe_stage_t st_reg  [0:NST-1];
    polyev_pkg::pe_stage_t st_next [0:NST-1];
    logic [NST-1:0]        vld_reg;
    logic [NST-1:0]        vld_in;
    logic [NST:0]          adv;
    logic                  in_fire;

    logic                  out_valid_reg;
    polyev_pkg::pe_out_t   out_data_reg;
    polyev_pkg::pe_out_t   out_next;

    assign adv[NST]  = !out_valid_reg || !out_stall;
    assign in_stall  = !adv[0] || div_busy_reg;
    assign in_fire   = in_valid && !in_stall;
    assign vld_in[0] = in_fire;

    for (genvar k = 0; k < NST; k++)
    begin : g_adv
        assign adv[k] = !vld_reg[k] || adv[k+1];
        if (k > 0)
        begin : g_vin
            assign vld_in[k] = vld_reg[k-1];
        end
    end

    // entry: accumulator starts at zero for evaluations and at the top padded integral coefficient for integrals
    always_comb
    begin
        logic signed [31:0] init;
        init = (in_data.req_type == polyev_pkg::REQ_INTEGRAL) ? init_int : '0;
        st_next[0].req_type = in_data.req_type;
        st_next[0].xa       = in_data.point_or_lower;
        st_next[0].xb       = in_data.upper_bound;
        st_next[0].va       = {{32{init[31]}}, init};
        st_next[0].vb       = {{32{init[31]}}, init};
        st_next[0].ovf      = 1'b0;
    end

    for (genvar s = 0; s < NSTEP; s++)
    begin : g_step
        localparam int J = MAX_DEGREE - s;

        always_comb
        begin
            st_next[2*s+1]    = st_reg[2*s];
            st_next[2*s+1].va = $signed(st_reg[2*s].va[31:0]) * $signed(st_reg[2*s].xa);
            st_next[2*s+1].vb = $signed(st_reg[2*s].vb[31:0]) * $signed(st_reg[2*s].xb);
        end

        always_comb
        begin
            logic signed [31:0] c;
            logic [32:0]        ra;
            logic [32:0]        rb;
            c  = (st_reg[2*s+1].req_type == polyev_pkg::REQ_INTEGRAL) ? cf_int[J] : cf_eval[J];
            ra = horner_add(st_reg[2*s+1].va, c);
            rb = horner_add(st_reg[2*s+1].vb, c);
            st_next[2*s+2]     = st_reg[2*s+1];
            st_next[2*s+2].va  = {{32{ra[31]}}, ra[31:0]};
            st_next[2*s+2].vb  = {{32{rb[31]}}, rb[31:0]};
            // upper-bound lane only counts for integrals
            st_next[2*s+2].ovf = st_reg[2*s+1].ovf | ra[32]
                                 | ((st_reg[2*s+1].req_type == polyev_pkg::REQ_INTEGRAL)
                                    & rb[32]);
        end
    end

    // final: F(b) - F(a) for integrals
    always_comb
    begin
        logic signed [32:0] diff;
        logic               dsat;
        logic [31:0]        dval;
        diff = $signed({st_reg[NST-1].vb[31], st_reg[NST-1].vb[31:0]})
               - $signed({st_reg[NST-1].va[31], st_reg[NST-1].va[31:0]});
        dsat = diff[32] != diff[31];
        dval = dsat ? (diff[32] ? 32'h8000_0000 : 32'h7fff_ffff) : diff[31:0];
        if (st_reg[NST-1].req_type == polyev_pkg::REQ_INTEGRAL)
        begin
            out_next.result_value = dval;
            out_next.overflow     = st_reg[NST-1].ovf | dsat;
        end
        else
        begin
            out_next.result_value = st_reg[NST-1].va[31:0];
            out_next.overflow     = st_reg[NST-1].ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int k = 0; k < NST; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_in[k];
                end
            end
            if (adv[NST])
            begin
                out_valid_reg <= vld_reg[NST-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NST; k++)
        begin
            if (adv[k])
            begin
                st_reg[k] <= st_next[k];
            end
        end
        if (adv[NST])
        begin
            out_data_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    // no request may enter while an integral coefficient is still being divided
    a_no_entry_while_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_busy_reg |-> in_stall)
        else $error("request accepted during coefficient division");

    a_coef_write_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready && cfg_index >= polyev_pkg::REG_COEF0
         && cfg_index < COEF_END) |=> div_busy_reg)
        else $error("coefficient write did not start the divider");

    // last stage must hold its item while the output register is blocked
    a_last_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[NST-1] && out_valid_reg && out_stall) |=> vld_reg[NST-1])
        else $error("item dropped from last pipeline stage");

    a_out_from_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(out_valid_reg)) |-> $past(vld_reg[NST-1]))
        else $error("output appeared without a pipeline item");
`endif

endmodule
